// File: sv/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and arithmetic helpers for the stereo crosstalk
// canceller: word formats, register map and rounding/saturation functions.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Sample and coefficient widths
  localparam int SW   = 24;   // sample width, signed Q1.23
  localparam int GW   = 18;   // gain width, unsigned Q2.16
  localparam int FW   = 16;   // fraction width, unsigned Q0.16
  localparam int DFW  = 12;   // delay length register width
  localparam int PAW  = 5;    // APB address width
  localparam int PDW  = 32;   // APB data width

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  // Register reset values
  localparam logic          RST_ENABLE   = 1'b1;
  localparam logic [GW-1:0] RST_IN_GAIN  = 18'd45875;
  localparam logic [GW-1:0] RST_DECAY    = 18'd49145;
  localparam logic [GW-1:0] RST_CENTER   = 18'd45875;
  localparam logic [GW-1:0] RST_END_GAIN = 18'd93617;
  localparam logic [DFW-1:0] RST_DELAY   = 12'd2;
  localparam logic [FW-1:0] RST_FRACTION = 16'd24756;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ENABLE         = 3'd0,
    REG_INPUT_GAIN     = 3'd1,
    REG_DECAY_GAIN     = 3'd2,
    REG_CENTER_GAIN    = 3'd3,
    REG_END_GAIN       = 3'd4,
    REG_DELAY_FRAMES   = 3'd5,
    REG_DELAY_FRACTION = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic           enable;
    logic [GW-1:0]  input_gain;
    logic [GW-1:0]  decay_gain;
    logic [GW-1:0]  center_gain;
    logic [GW-1:0]  end_gain;
    logic [DFW-1:0] delay_frames;
    logic [FW-1:0]  delay_fraction;
  } cfg_t;

  typedef struct packed {
    logic signed [SW-1:0] in_left;
    logic signed [SW-1:0] in_right;
  } in_word_t;

  typedef struct packed {
    logic signed [SW-1:0] out_left;
    logic signed [SW-1:0] out_right;
  } out_word_t;

  // One stereo raw frame as held in the delay store
  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } frame_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_MIX,
    ST_FB,
    ST_OUT
  } st_t;

  // Round half up then arithmetic shift right
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    rnd_shr = (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Saturate to a sample
  function automatic logic signed [SW-1:0] sat_s(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (v > SMAX) t = SMAX;
    else if (v < SMIN) t = SMIN;
    sat_s = t[SW-1:0];
  endfunction

endpackage

// File: sv/stereo_crosstalk_canceller_top.sv
// ----------------------------------------------------------------------------
// stereo_crosstalk_canceller_top
// Recursive stereo crosstalk canceller with a circular delay store.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall/in_data) takes one stereo frame per
//    word; a word is taken when in_valid is high and in_stall low.
//  - Output channel (out_valid/out_stall/out_data) gives one frame per input
//    word, held in an output register until taken.
//  - One word is processed at a time: with enable high the sequencer visits
//    six states, set by the two reads of the single-read-port delay store plus
//    the chained multiply stages, before it takes the next word.
//  - The next word is accepted while a finished result waits; a stalled
//    output only holds the sequencer once the next result is ready.
//  - When enable is 0 a word goes straight to the output register and the
//    store is left untouched.
//  - Reset and any write to a defined register empty the delay store at once
//    through a fill count: no clearing pass. Registers must be written over APB
//    while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stereo_crosstalk_canceller_top #(
  parameter int MAX_DELAY_FRAMES = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  scc_pkg::in_word_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output scc_pkg::out_word_t       out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [scc_pkg::PAW-1:0]  paddr,
  input  logic [scc_pkg::PDW-1:0]  pwdata,
  output logic [scc_pkg::PDW-1:0]  prdata,
  output logic                     pready
);
  import scc_pkg::*;

  localparam int AW = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;

  cfg_t          cfg;
  logic          clr;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  frame_t        rd_data, wr_data;

  // Configuration registers
  scc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clr     (clr)
  );

  // Delay store
  scc_store #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
    .AW               (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Sequencer and datapath
  scc_core #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
    .AW               (AW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clr       (clr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

// File: sv/scc_regs.sv
// ----------------------------------------------------------------------------
// scc_regs
// APB register file. Holds the configuration and flags a store clear on any
// write to a defined register.
// ----------------------------------------------------------------------------
module scc_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [scc_pkg::PAW-1:0]  paddr,
  input  logic [scc_pkg::PDW-1:0]  pwdata,
  output logic [scc_pkg::PDW-1:0]  prdata,
  output logic                     pready,
  output scc_pkg::cfg_t            cfg,
  output logic                     clr
);
  import scc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;
  logic     hit;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PAW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;
  assign clr    = wr && hit;

  // Decode: is the word a defined register
  always_comb begin
    unique case (idx)
      REG_ENABLE, REG_INPUT_GAIN, REG_DECAY_GAIN, REG_CENTER_GAIN,
      REG_END_GAIN, REG_DELAY_FRAMES, REG_DELAY_FRACTION: hit = 1'b1;
      default: hit = 1'b0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= RST_ENABLE;
      cfg_r.input_gain     <= RST_IN_GAIN;
      cfg_r.decay_gain     <= RST_DECAY;
      cfg_r.center_gain    <= RST_CENTER;
      cfg_r.end_gain       <= RST_END_GAIN;
      cfg_r.delay_frames   <= RST_DELAY;
      cfg_r.delay_fraction <= RST_FRACTION;
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE:         cfg_r.enable         <= pwdata[0];
        REG_INPUT_GAIN:     cfg_r.input_gain     <= pwdata[GW-1:0];
        REG_DECAY_GAIN:     cfg_r.decay_gain     <= pwdata[GW-1:0];
        REG_CENTER_GAIN:    cfg_r.center_gain    <= pwdata[GW-1:0];
        REG_END_GAIN:       cfg_r.end_gain       <= pwdata[GW-1:0];
        REG_DELAY_FRAMES:   cfg_r.delay_frames   <= pwdata[DFW-1:0];
        REG_DELAY_FRACTION: cfg_r.delay_fraction <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      REG_ENABLE:         prdata = PDW'(cfg_r.enable);
      REG_INPUT_GAIN:     prdata = PDW'(cfg_r.input_gain);
      REG_DECAY_GAIN:     prdata = PDW'(cfg_r.decay_gain);
      REG_CENTER_GAIN:    prdata = PDW'(cfg_r.center_gain);
      REG_END_GAIN:       prdata = PDW'(cfg_r.end_gain);
      REG_DELAY_FRAMES:   prdata = PDW'(cfg_r.delay_frames);
      REG_DELAY_FRACTION: prdata = PDW'(cfg_r.delay_fraction);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: sv/scc_store.sv
// ----------------------------------------------------------------------------
// scc_store
// Delay store: single-port-write, single-port-read synchronous memory of
// stereo raw frames, with a registered read.
// ----------------------------------------------------------------------------
module scc_store #(
  parameter int MAX_DELAY_FRAMES = 2048,
  parameter int AW               = 11
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output scc_pkg::frame_t      rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  scc_pkg::frame_t      wr_data
);
  import scc_pkg::*;

  frame_t mem [MAX_DELAY_FRAMES];
  frame_t rd_data_r;

  assign rd_data = rd_data_r;

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// File: sv/scc_core.sv
// ----------------------------------------------------------------------------
// scc_core
// Sequencer and datapath: reads two delayed frames from the store,
// interpolates, applies cross feedback, writes the raw frame back and forms
// the centre-mixed, end-gained output word; enable low passes input through.
// ----------------------------------------------------------------------------
module scc_core #(
  parameter int MAX_DELAY_FRAMES = 2048,
  parameter int AW               = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scc_pkg::cfg_t        cfg,
  input  logic                 clr,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scc_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scc_pkg::out_word_t   out_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  scc_pkg::frame_t      rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output scc_pkg::frame_t      wr_data
);
  import scc_pkg::*;

  localparam int LW = $clog2(MAX_DELAY_FRAMES + 1);
  localparam logic [LW-1:0] MAXN = LW'(MAX_DELAY_FRAMES);

  // Control state
  st_t             state_r, state_nxt;
  logic [AW-1:0]   idx_r;
  logic [LW-1:0]   fill_r;
  logic            rdok_r;
  logic            byp_r;
  logic            out_valid_r;

  // Payload
  in_word_t                x_r;
  logic [2*GW-1:0]         pcg_r;
  logic signed [SW-1:0]    s_l_r, s_r_r;
  logic signed [41:0]      pa_l_r, pa_r_r;
  logic signed [25:0]      d_l_r, d_r_r;
  logic signed [43:0]      cpl_r, cph_r;
  logic signed [SW-1:0]    r_l_r, r_r_r;
  logic signed [29:0]      c_r;
  out_word_t               out_data_r;

  // Control strobes
  logic accept, ld_out;

  // Active delay length and next position
  logic [LW-1:0] n;
  logic [LW:0]   inc_w, nxt_w;
  logic [AW-1:0] nxt_idx;
  logic          idx_ok, nxt_ok;

  // Datapath wires
  logic signed [GW:0]      ig_s, dg_s, eg_s;
  logic [FW:0]             inv;
  logic signed [FW+1:0]    inv_s;
  logic signed [FW:0]      fr_s;
  logic signed [42:0]      m_s_l, m_s_r;
  logic signed [SW-1:0]    a_l, a_r, b_l, b_r;
  logic signed [41:0]      pd_l, pd_r;
  logic signed [SW:0]      ssum;
  logic signed [44:0]      fb_l, fb_r;
  logic signed [63:0]      cacc;
  logic signed [30:0]      rc_l, rc_r;
  logic signed [49:0]      eo_l, eo_r;

  // Length clamp: zero counts as one, long delays saturate
  always_comb begin
    if (cfg.delay_frames == '0) n = LW'(1);
    else if (32'(cfg.delay_frames) > 32'(MAX_DELAY_FRAMES)) n = MAXN;
    else n = LW'(cfg.delay_frames);
  end

  assign inc_w   = (LW+1)'(idx_r) + (LW+1)'(1);
  assign nxt_w   = (inc_w >= (LW+1)'(n)) ? '0 : inc_w;
  assign nxt_idx = nxt_w[AW-1:0];
  // An entry is live once written since the last clear
  assign idx_ok  = LW'(idx_r) < fill_r;
  assign nxt_ok  = (LW'(nxt_idx) < fill_r) && (n != LW'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = cfg.enable ? ST_RDA : ST_OUT;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_FB;
      ST_FB:   state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    accept   = (state_r == ST_IDLE) && in_valid;
    ld_out   = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
    rd_en    = 1'b0;
    rd_addr  = idx_r;
    wr_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: rd_en = in_valid && cfg.enable;
      ST_RDA: begin
        rd_en   = 1'b1;
        rd_addr = nxt_idx;
      end
      ST_FB:   wr_en = 1'b1;
      default: ;
    endcase
  end

  assign wr_addr       = idx_r;
  assign wr_data.left  = r_l_r;
  assign wr_data.right = r_r_r;

  // Arithmetic
  always_comb begin
    ig_s  = $signed({1'b0, cfg.input_gain});
    dg_s  = $signed({1'b0, cfg.decay_gain});
    eg_s  = $signed({1'b0, cfg.end_gain});
    inv   = 17'h10000 - {1'b0, cfg.delay_fraction};
    inv_s = $signed({1'b0, inv});
    fr_s  = $signed({1'b0, cfg.delay_fraction});

    // input scaling
    m_s_l = x_r.in_left * ig_s;
    m_s_r = x_r.in_right * ig_s;

    // delayed frames, dead entries read as zero
    a_l = rdok_r ? rd_data.left  : '0;
    a_r = rdok_r ? rd_data.right : '0;
    b_l = rdok_r ? rd_data.left  : '0;
    b_r = rdok_r ? rd_data.right : '0;

    // interpolation second tap
    pd_l = pa_l_r + b_l * fr_s;
    pd_r = pa_r_r + b_r * fr_s;

    // centre sum and cross feedback
    ssum = (SW+1)'(s_l_r) + (SW+1)'(s_r_r);
    fb_l = dg_s * d_r_r;
    fb_r = dg_s * d_l_r;

    // centre product recombined from its two halves
    cacc = 64'(cpl_r) + (64'(cph_r) <<< GW);

    // end gain
    rc_l = 31'(r_l_r) + 31'(c_r);
    rc_r = 31'(r_r_r) + 31'(c_r);
    eo_l = eg_s * rc_l;
    eo_r = eg_s * rc_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        idx_r  <= '0;
        fill_r <= '0;
      end else if (state_r == ST_FB) begin
        idx_r <= nxt_idx;
        if (fill_r < n) fill_r <= fill_r + LW'(1);
      end
      if (ld_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_data;
      byp_r  <= !cfg.enable;
      rdok_r <= idx_ok;
      pcg_r  <= cfg.center_gain * cfg.input_gain;
    end
    unique case (state_r)
      ST_RDA: begin
        s_l_r  <= sat_s(rnd_shr(64'(m_s_l), 16));
        s_r_r  <= sat_s(rnd_shr(64'(m_s_r), 16));
        pa_l_r <= a_l * inv_s;
        pa_r_r <= a_r * inv_s;
        rdok_r <= nxt_ok;
      end
      ST_RDB: begin
        d_l_r <= 26'(rnd_shr(64'(pd_l), 16));
        d_r_r <= 26'(rnd_shr(64'(pd_r), 16));
        cpl_r <= ssum * $signed({1'b0, pcg_r[GW-1:0]});
      end
      ST_MIX: begin
        r_l_r <= sat_s(64'(s_l_r) - rnd_shr(64'(fb_l), 16));
        r_r_r <= sat_s(64'(s_r_r) - rnd_shr(64'(fb_r), 16));
        cph_r <= ssum * $signed({1'b0, pcg_r[2*GW-1:GW]});
      end
      ST_FB:   c_r <= 30'(rnd_shr(cacc, 33));
      default: ;
    endcase
    // output word
    if (ld_out) begin
      if (byp_r) begin
        out_data_r.out_left  <= x_r.in_left;
        out_data_r.out_right <= x_r.in_right;
      end else begin
        out_data_r.out_left  <= sat_s(rnd_shr(64'(eo_l), 16));
        out_data_r.out_right <= sat_s(rnd_shr(64'(eo_r), 16));
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks on the canceller, bound to the top level.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input scc_pkg::out_word_t  out_data
);
  import scc_pkg::*;

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output word changed while stalled");

  // One word in flight: intake closes right after a word is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind stereo_crosstalk_canceller_top scc_checker u_scc_checker (.*);

// File: tb/stereo_crosstalk_canceller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_crosstalk_canceller_top_test
// Self-checking bench for the stereo crosstalk canceller. Frames go in over
// the valid/stall channel, and a bit-exact predictor with its own copy of the
// delay store and registers works out each output frame. Results are checked
// in order, field by field. Registers are set over APB between phases: reset
// values, delay edge cases, bypass, read-back, random settings under several
// idling patterns, and a long output hold that fills the block.
// ----------------------------------------------------------------------------
module stereo_crosstalk_canceller_top_test;
  import scc_pkg::*;

  localparam int     MAX_FRAMES    = 2048;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     RANDOM_PHASES = 24;
  localparam int     REPORT_LIMIT  = 10;
  localparam int     UNLISTED_REG  = 7;
  localparam longint TIMEOUT_NS    = 5_000_000;

  localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [GW-1:0] GAIN_MAX   = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [PAW-1:0]   paddr;
  logic [PDW-1:0]   pwdata;
  logic [PDW-1:0]   prdata;
  logic             pready;

  // Predictor state: registers, raw-frame delay store and write position
  cfg_t      model_cfg;
  longint    echo_l [MAX_FRAMES];
  longint    echo_r [MAX_FRAMES];
  int        echo_pos;
  out_word_t frames_due [$];

  // Idling controls and run statistics
  int   gap_pct;
  int   stall_pct;
  logic long_hold = 1'b0;
  event hold_request;
  int   fail_count;
  int   frames_sent;
  int   results_seen;
  int   input_held_cycles;
  int   phases_run;

  stereo_crosstalk_canceller_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Round half up, then arithmetic shift
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip_sample(longint v);
    if (v > longint'(SMAX)) return longint'(SMAX);
    if (v < longint'(SMIN)) return longint'(SMIN);
    return v;
  endfunction

  function automatic void clear_echo();
    for (int i = 0; i < MAX_FRAMES; i++) begin
      echo_l[i] = 0;
      echo_r[i] = 0;
    end
    echo_pos = 0;
  endfunction

  // Listed registers also flush the delay store; an unlisted index is ignored
  function automatic void apply_register(int idx, logic [PDW-1:0] v);
    case (idx)
      REG_ENABLE:         model_cfg.enable         = v[0];
      REG_INPUT_GAIN:     model_cfg.input_gain     = v[GW-1:0];
      REG_DECAY_GAIN:     model_cfg.decay_gain     = v[GW-1:0];
      REG_CENTER_GAIN:    model_cfg.center_gain    = v[GW-1:0];
      REG_END_GAIN:       model_cfg.end_gain       = v[GW-1:0];
      REG_DELAY_FRAMES:   model_cfg.delay_frames   = v[DFW-1:0];
      REG_DELAY_FRACTION: model_cfg.delay_fraction = v[FW-1:0];
      default:            return;
    endcase
    clear_echo();
  endfunction

  function automatic logic [PDW-1:0] register_value(int idx);
    case (idx)
      REG_ENABLE:         return PDW'(model_cfg.enable);
      REG_INPUT_GAIN:     return PDW'(model_cfg.input_gain);
      REG_DECAY_GAIN:     return PDW'(model_cfg.decay_gain);
      REG_CENTER_GAIN:    return PDW'(model_cfg.center_gain);
      REG_END_GAIN:       return PDW'(model_cfg.end_gain);
      REG_DELAY_FRAMES:   return PDW'(model_cfg.delay_frames);
      default:            return PDW'(model_cfg.delay_fraction);
    endcase
  endfunction

  // One frame through the canceller, updating the delay store
  function automatic out_word_t cancel_frame(in_word_t w);
    longint    xl, xr, sl, sr, fr, inv, dl, dr, rl, rr, mid, ol, orr;
    longint    g_in, g_decay, g_mid, g_end;
    int        n, rd, nx;
    out_word_t o;
    if (!model_cfg.enable) begin
      o.out_left  = w.in_left;
      o.out_right = w.in_right;
      return o;
    end
    xl      = $signed(w.in_left);
    xr      = $signed(w.in_right);
    g_in    = longint'(model_cfg.input_gain);
    g_decay = longint'(model_cfg.decay_gain);
    g_mid   = longint'(model_cfg.center_gain);
    g_end   = longint'(model_cfg.end_gain);
    n = int'(model_cfg.delay_frames);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    rd = (echo_pos >= n) ? 0 : echo_pos;
    nx = (rd + 1 >= n) ? 0 : rd + 1;

    sl = clip_sample(round_shift(xl * g_in, 16));
    sr = clip_sample(round_shift(xr * g_in, 16));

    // Fractional delay; with a one-frame delay the later tap counts as zero
    fr  = longint'(model_cfg.delay_fraction);
    inv = 65536 - fr;
    if (n > 1) begin
      dl = round_shift(echo_l[rd] * inv + echo_l[nx] * fr, 16);
      dr = round_shift(echo_r[rd] * inv + echo_r[nx] * fr, 16);
    end else begin
      dl = round_shift(echo_l[rd] * inv, 16);
      dr = round_shift(echo_r[rd] * inv, 16);
    end

    rl = clip_sample(sl - round_shift(g_decay * dr, 16));
    rr = clip_sample(sr - round_shift(g_decay * dl, 16));
    echo_l[rd] = rl;
    echo_r[rd] = rr;
    echo_pos   = nx;

    mid = round_shift((sl + sr) * g_mid * g_in, 33);
    ol  = clip_sample(round_shift(g_end * (rl + mid), 16));
    orr = clip_sample(round_shift(g_end * (rr + mid), 16));
    o.out_left  = ol[SW-1:0];
    o.out_right = orr[SW-1:0];
    return o;
  endfunction

  // Append a predicted word behind those still awaited
  function automatic void queue_expected(out_word_t o);
    frames_due = {frames_due, o};
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern, long hold and result checking
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= long_hold || (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
  end

  // Long output hold, counted in cycles
  initial begin : receiver_hold
    forever begin
      @(hold_request);
      @(posedge clk);
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold = 1'b0;
    end
  end

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_stall) input_held_cycles++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (frames_due.size() == 0) begin
          log_failure($sformatf("unexpected output word left %0d right %0d",
                                $signed(out_data.out_left), $signed(out_data.out_right)));
        end else begin
          want = frames_due.pop_front();
          if (out_data.out_left !== want.out_left)
            log_failure($sformatf("out_left: expected %0d, got %0d",
                                  $signed(want.out_left), $signed(out_data.out_left)));
          if (out_data.out_right !== want.out_right)
            log_failure($sformatf("out_right: expected %0d, got %0d",
                                  $signed(want.out_right), $signed(out_data.out_right)));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side and register access; every task starts and ends just after a
  // falling edge with no pending update in that step
  // ---------------------------------------------------------------------------

  task automatic send_frame(input logic [SW-1:0] left, input logic [SW-1:0] right);
    in_word_t w;
    w.in_left  = left;
    w.in_right = right;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_expected(cancel_frame(w));
    frames_sent++;
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding word come out
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [PDW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAW'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input int idx);
    logic [PDW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PAW'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got !== register_value(idx))
      log_failure($sformatf("register %0d read: expected %0h, got %0h",
                            idx, register_value(idx), got));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 71; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 71; end
      IDLE_BOTH:     begin gap_pct = 21; stall_pct = 21; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SW'($urandom_range(0, 2000) - 1000);
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic [PDW-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PDW'(GAIN_MAX);
      2:       return PDW'($urandom_range(0, 262143));
      default: return PDW'($urandom_range(20000, 100000));
    endcase
  endfunction

  function automatic logic [PDW-1:0] rand_delay();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 1;
      2:       return MAX_FRAMES;
      3:       return 4095;
      4:       return $urandom_range(9, 200);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [PDW-1:0] rand_fraction();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values, sample extremes and every bit both ways
  task automatic test_reset_defaults();
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame('0, '0);
    send_frame(SW'(1), '1);
    send_frame(24'h555555, 24'hAAAAAA);
    send_frame(24'hAAAAAA, 24'h555555);
  endtask

  // One-frame delay, zero taken as one, length beyond the store clamped
  task automatic test_delay_edges();
    wait_idle();
    write_reg(REG_DELAY_FRAMES, 1);
    write_reg(REG_DELAY_FRACTION, PDW'(16'h8000));
    send_frame(SAMPLE_MAX, '0);
    send_frame('0, SAMPLE_MIN);
    send_frame(24'h400000, 24'hC00000);
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    wait_idle();
    write_reg(REG_DELAY_FRAMES, 0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(24'h123456, 24'hFEDCBA);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    wait_idle();
    write_reg(REG_DELAY_FRAMES, 4095);
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, '0);
    send_frame(24'h0F0F0F, 24'hF0F0F0);
  endtask

  // Enable low copies frames straight through
  task automatic test_bypass();
    wait_idle();
    write_reg(REG_ENABLE, 0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(24'h555555, 24'hAAAAAA);
    send_frame('0, '1);
    wait_idle();
    write_reg(REG_ENABLE, 1);
  endtask

  // A write past the register list must leave registers and store alone
  task automatic test_unlisted_register();
    send_frame(24'h300000, 24'hD00000);
    wait_idle();
    write_reg(UNLISTED_REG, '1);
    send_frame('0, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
  endtask

  // Write all-ones and all-zeros, read every register back
  task automatic test_register_readback();
    wait_idle();
    for (int i = REG_ENABLE; i <= REG_DELAY_FRACTION; i++) write_reg(i, '1);
    for (int i = REG_ENABLE; i <= REG_DELAY_FRACTION; i++) check_reg(i);
    for (int i = REG_ENABLE; i <= REG_DELAY_FRACTION; i++) write_reg(i, '0);
    for (int i = REG_ENABLE; i <= REG_DELAY_FRACTION; i++) check_reg(i);
  endtask

  // Random settings per phase, cycling through the idling patterns
  task automatic test_random_settings();
    int count;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p == 0) begin
        write_reg(REG_ENABLE, 1);
        for (int i = REG_INPUT_GAIN; i <= REG_END_GAIN; i++) write_reg(i, PDW'(GAIN_MAX));
        write_reg(REG_DELAY_FRAMES, 4095);
        write_reg(REG_DELAY_FRACTION, 65535);
      end else if (p == 1) begin
        write_reg(REG_ENABLE, 1);
        for (int i = REG_INPUT_GAIN; i <= REG_END_GAIN; i++) write_reg(i, 0);
        write_reg(REG_DELAY_FRAMES, 1);
        write_reg(REG_DELAY_FRACTION, 0);
      end else begin
        write_reg(REG_ENABLE, ($urandom_range(0, 7) == 0) ? 0 : 1);
        for (int i = REG_INPUT_GAIN; i <= REG_END_GAIN; i++) write_reg(i, rand_gain());
        write_reg(REG_DELAY_FRAMES, rand_delay());
        write_reg(REG_DELAY_FRACTION, rand_fraction());
      end
      set_idle(idle_mode_t'(p % 4));
      phases_run++;
      count = $urandom_range(30, 50);
      repeat (count) send_frame(rand_sample(), rand_sample());
    end
    set_idle(IDLE_NONE);
  endtask

  // Hold the output for a long stretch while frames keep coming
  task automatic test_output_hold();
    wait_idle();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_DELAY_FRAMES, 3);
    set_idle(IDLE_NONE);
    -> hold_request;
    repeat (24) send_frame(rand_sample(), rand_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gap_pct  = 0;
    stall_pct = 0;
    fail_count = 0;
    frames_sent = 0;
    results_seen = 0;
    input_held_cycles = 0;
    phases_run = 0;
    model_cfg = '{enable: RST_ENABLE, input_gain: RST_IN_GAIN, decay_gain: RST_DECAY,
                  center_gain: RST_CENTER, end_gain: RST_END_GAIN,
                  delay_frames: RST_DELAY, delay_fraction: RST_FRACTION};
    clear_echo();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_delay_edges();
    test_bypass();
    test_unlisted_register();
    test_register_readback();
    test_random_settings();
    test_output_hold();
    wait_idle();

    if (frames_due.size() != 0)
      log_failure($sformatf("%0d output words never arrived", frames_due.size()));
    $display("Ran %0d frames (%0d results) over %0d random settings plus reset values,",
             frames_sent, results_seen, phases_run);
    $display("delay edges, bypass, register read-back and a long hold (%0d input stall cycles).",
             input_held_cycles);
    if (fail_count == 0) begin
      $display("PASS stereo_crosstalk_canceller_top");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("FAIL stereo_crosstalk_canceller_top");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d output words outstanding", frames_due.size());
    $display("FAIL stereo_crosstalk_canceller_top");
    $finish;
  end

endmodule
